// ===== hdl/ffec_pkg.sv =====
// Shared types, codes and decode helpers for the four-floor elevator controller.
package ffec_pkg;

    // Field widths
    localparam int unsigned FLOOR_W = 3;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned MOTOR_W = 2;
    localparam int unsigned INDEX_W = 2;
    localparam int unsigned HALL_W  = 3;

    // Configuration register indexes
    localparam int unsigned    CFG_COUNT     = 2;
    localparam int unsigned    CFG_INDEX_W   = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UP_DUTY   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_DUTY = 1'd1;

    // Reset values
    localparam logic [DUTY_W-1:0] UP_DUTY_RST   = 10'd400;
    localparam logic [DUTY_W-1:0] DOWN_DUTY_RST = 10'd300;
    localparam logic [DUTY_W-1:0] DUTY_RST      = 10'd500;

    // Floor numbers
    localparam logic [FLOOR_W-1:0] FLOOR_NONE = 3'd0;
    localparam logic [FLOOR_W-1:0] FLOOR_1    = 3'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_2    = 3'd2;
    localparam logic [FLOOR_W-1:0] FLOOR_3    = 3'd3;
    localparam logic [FLOOR_W-1:0] FLOOR_4    = 3'd4;

    // Motor command codes
    localparam logic [MOTOR_W-1:0] MOT_STOP = 2'd0;
    localparam logic [MOTOR_W-1:0] MOT_UP   = 2'd1;
    localparam logic [MOTOR_W-1:0] MOT_DOWN = 2'd2;

    // Reported mode codes
    localparam logic [MODE_W-1:0] MODE_INIT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DNC  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UPR  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DNR  = 3'd6;

    // Hall call codes
    localparam logic [HALL_W-1:0] HALL_F1_UP   = 3'd7;
    localparam logic [HALL_W-1:0] HALL_F2_DOWN = 3'd6;
    localparam logic [HALL_W-1:0] HALL_F2_UP   = 3'd5;
    localparam logic [HALL_W-1:0] HALL_F3_DOWN = 3'd4;
    localparam logic [HALL_W-1:0] HALL_F3_UP   = 3'd3;
    localparam logic [HALL_W-1:0] HALL_F4_DOWN = 3'd2;

    // One-hot controller state
    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_UPC  = 7'b0000100,
        ST_DNC  = 7'b0001000,
        ST_WAIT = 7'b0010000,
        ST_UPR  = 7'b0100000,
        ST_DNR  = 7'b1000000
    } t_state;

    // One poll tick
    typedef struct packed {
        logic               limit_hit;
        logic [INDEX_W-1:0] limit_index;
        logic               cab_hit;
        logic [INDEX_W-1:0] cab_index;
        logic               hall_hit;
        logic [HALL_W-1:0]  hall_code;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [MOTOR_W-1:0] motor_cmd;
        logic [DUTY_W-1:0]  duty;
        logic [FLOOR_W-1:0] display_floor;
        logic [MODE_W-1:0]  mode;
    } t_out_item;

    // Decoded hall call
    typedef struct packed {
        logic               valid;
        logic [FLOOR_W-1:0] floor;
        logic               going_up;
    } t_hall_call;

    // Map a hall code to its floor and direction
    function automatic t_hall_call hall_decode(input logic [HALL_W-1:0] code);
        t_hall_call c;
        c.valid    = 1'b1;
        c.floor    = FLOOR_NONE;
        c.going_up = 1'b0;
        case (code)
            HALL_F1_UP: begin
                c.floor    = FLOOR_1;
                c.going_up = 1'b1;
            end
            HALL_F2_DOWN: c.floor = FLOOR_2;
            HALL_F2_UP: begin
                c.floor    = FLOOR_2;
                c.going_up = 1'b1;
            end
            HALL_F3_DOWN: c.floor = FLOOR_3;
            HALL_F3_UP: begin
                c.floor    = FLOOR_3;
                c.going_up = 1'b1;
            end
            HALL_F4_DOWN: c.floor = FLOOR_4;
            default: c.valid = 1'b0;
        endcase
        return c;
    endfunction

    // Report code of a one-hot state
    function automatic logic [MODE_W-1:0] state_code(input t_state s);
        logic [MODE_W-1:0] m;
        case (s)
            ST_INIT: m = MODE_INIT;
            ST_IDLE: m = MODE_IDLE;
            ST_UPC:  m = MODE_UPC;
            ST_DNC:  m = MODE_DNC;
            ST_WAIT: m = MODE_WAIT;
            ST_UPR:  m = MODE_UPR;
            ST_DNR:  m = MODE_DNR;
            default: m = MODE_INIT;
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/four_floor_elevator_controller.sv =====
// Top level of the four-floor elevator controller: tick decode, mode machine, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in  (limit, cab, hall switch groups)
//  out     | output    | o_out_valid / i_out_stall | o_out (motor, duty, floor, mode)
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One tick is taken per cycle while the input is not stalled; its result shows in the result register the cycle after.
// The whole state update is one pass of combinational logic into the state registers.
// Reset is synchronous and active low; it loads the reset state and duties and clears result valid.
// Input is stalled only while a held result is itself stalled downstream.
module four_floor_elevator_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ffec_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ffec_pkg::t_out_item                   o_out,
    input  logic                                  i_cfg_wr_en,
    input  logic [ffec_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ffec_pkg::DUTY_W-1:0]           i_cfg_data
);

    // Configuration registers
    logic [ffec_pkg::DUTY_W-1:0]  r_up_duty;
    logic [ffec_pkg::DUTY_W-1:0]  r_down_duty;

    // Controller state
    ffec_pkg::t_state             r_state, n_state;
    logic [ffec_pkg::FLOOR_W-1:0] r_floor_now, n_floor_now;
    logic [ffec_pkg::FLOOR_W-1:0] r_call_floor, n_call_floor;
    logic [ffec_pkg::FLOOR_W-1:0] r_target, n_target;
    logic                         r_trip_up, n_trip_up;
    logic [ffec_pkg::DUTY_W-1:0]  r_duty, n_duty;
    logic [ffec_pkg::FLOOR_W-1:0] r_shown, n_shown;

    // Result register
    logic                         r_out_valid;
    ffec_pkg::t_out_item          r_out;
    logic [ffec_pkg::MOTOR_W-1:0] n_motor;

    logic                         in_xfer;
    ffec_pkg::t_hall_call         hall;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign hall        = ffec_pkg::hall_decode(i_in.hall_code);

    // Apply switch groups in order, then run the mode machine once
    always_comb begin
        n_floor_now  = r_floor_now;
        n_shown      = r_shown;
        n_target     = r_target;
        n_state      = r_state;
        n_call_floor = r_call_floor;
        n_trip_up    = r_trip_up;
        n_duty       = r_duty;
        n_motor      = ffec_pkg::MOT_STOP;

        // Limit switch updates the floor
        if (i_in.limit_hit) begin
            n_floor_now = {1'b0, i_in.limit_index} + ffec_pkg::FLOOR_1;
            n_shown     = n_floor_now;
        end

        // Cab button always sets the destination; starts a trip only in wait
        if (i_in.cab_hit) begin
            n_target = {1'b0, i_in.cab_index} + ffec_pkg::FLOOR_1;
            if (r_state == ffec_pkg::ST_WAIT && n_target != n_floor_now) begin
                if (r_trip_up && n_target > n_floor_now) begin
                    n_state = ffec_pkg::ST_UPR;
                end else if (!r_trip_up && n_target < n_floor_now) begin
                    n_state = ffec_pkg::ST_DNR;
                end
            end
        end

        // Hall call taken only in idle
        if (i_in.hall_hit && hall.valid && n_state == ffec_pkg::ST_IDLE) begin
            n_call_floor = hall.floor;
            n_trip_up    = hall.going_up;
            if (n_floor_now == hall.floor) begin
                n_state = ffec_pkg::ST_WAIT;
            end else if (hall.floor == ffec_pkg::FLOOR_1 || n_floor_now > hall.floor) begin
                n_state = ffec_pkg::ST_DNC;
            end else begin
                n_state = ffec_pkg::ST_UPC;
            end
        end

        // Mode machine drives the motor and duty
        case (n_state)
            ffec_pkg::ST_INIT: begin
                if (n_floor_now == ffec_pkg::FLOOR_1) begin
                    n_state = ffec_pkg::ST_IDLE;
                end else begin
                    n_motor = ffec_pkg::MOT_DOWN;
                    n_duty  = r_down_duty;
                end
            end
            ffec_pkg::ST_UPC: begin
                if (n_call_floor == n_floor_now) begin
                    n_state = ffec_pkg::ST_WAIT;
                end else begin
                    n_motor = ffec_pkg::MOT_UP;
                    n_duty  = r_up_duty;
                end
            end
            ffec_pkg::ST_DNC: begin
                if (n_call_floor == n_floor_now) begin
                    n_state = ffec_pkg::ST_WAIT;
                end else begin
                    n_motor = ffec_pkg::MOT_DOWN;
                    n_duty  = r_down_duty;
                end
            end
            ffec_pkg::ST_UPR: begin
                if (n_target == n_floor_now) begin
                    n_state = ffec_pkg::ST_IDLE;
                end else begin
                    n_motor = ffec_pkg::MOT_UP;
                    n_duty  = r_up_duty;
                end
            end
            ffec_pkg::ST_DNR: begin
                if (n_target == n_floor_now) begin
                    n_state = ffec_pkg::ST_IDLE;
                end else begin
                    n_motor = ffec_pkg::MOT_DOWN;
                    n_duty  = r_down_duty;
                end
            end
            default: begin
                n_motor = ffec_pkg::MOT_STOP;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_duty   <= ffec_pkg::UP_DUTY_RST;
            r_down_duty <= ffec_pkg::DOWN_DUTY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ffec_pkg::CFG_UP_DUTY:   r_up_duty   <= i_cfg_data;
                ffec_pkg::CFG_DOWN_DUTY: r_down_duty <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ffec_pkg::ST_INIT;
            r_floor_now  <= ffec_pkg::FLOOR_NONE;
            r_call_floor <= ffec_pkg::FLOOR_NONE;
            r_target     <= ffec_pkg::FLOOR_NONE;
            r_trip_up    <= 1'b0;
            r_duty       <= ffec_pkg::DUTY_RST;
            r_shown      <= ffec_pkg::FLOOR_NONE;
        end else if (in_xfer) begin
            r_state      <= n_state;
            r_floor_now  <= n_floor_now;
            r_call_floor <= n_call_floor;
            r_target     <= n_target;
            r_trip_up    <= n_trip_up;
            r_duty       <= n_duty;
            r_shown      <= n_shown;
        end
    end

    // Hold the result until it transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out.motor_cmd     <= n_motor;
            r_out.duty          <= n_duty;
            r_out.display_floor <= n_shown;
            r_out.mode          <= ffec_pkg::state_code(n_state);
        end
    end

endmodule

// ===== hdl/ffec_checker.sv =====
// Port-level checker for the four-floor elevator controller, bound to the top level.
module ffec_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  ffec_pkg::t_out_item o_out
);

    // A held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Every input transfer produces a result next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("input transfer without result");

    // Upward drive only in the two upward modes
    a_up_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.motor_cmd == ffec_pkg::MOT_UP |->
            (o_out.mode == ffec_pkg::MODE_UPC || o_out.mode == ffec_pkg::MODE_UPR))
        else $error("motor up outside an upward mode");

    // Downward drive only in init or the downward modes
    a_down_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.motor_cmd == ffec_pkg::MOT_DOWN |->
            (o_out.mode == ffec_pkg::MODE_INIT || o_out.mode == ffec_pkg::MODE_DNC ||
             o_out.mode == ffec_pkg::MODE_DNR))
        else $error("motor down outside a downward mode");

    // Stopped in idle and wait
    a_stop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.mode == ffec_pkg::MODE_IDLE ||
                        o_out.mode == ffec_pkg::MODE_WAIT) |->
            o_out.motor_cmd == ffec_pkg::MOT_STOP)
        else $error("motor running while idle or waiting");

endmodule

bind four_floor_elevator_controller ffec_checker u_ffec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the four-floor elevator controller: directed walk, then random trips.
module testbench;

    // Hall codes that the controller ignores
    localparam logic [ffec_pkg::HALL_W-1:0] HALL_IGNORED_0 = 3'd0;
    localparam logic [ffec_pkg::HALL_W-1:0] HALL_IGNORED_1 = 3'd1;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    ffec_pkg::t_in_item               i_in;
    logic                             o_out_valid;
    logic                             i_out_stall;
    ffec_pkg::t_out_item              o_out;
    logic                             i_cfg_wr_en;
    logic [ffec_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [ffec_pkg::DUTY_W-1:0]      i_cfg_data;

    four_floor_elevator_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // One directed step: the tick and, where typed in, its known status
    typedef struct {
        ffec_pkg::t_in_item  tick;
        bit                  typed;
        ffec_pkg::t_out_item status;
    } t_script_row;

    // Shadow of the car and its settings
    logic [ffec_pkg::MODE_W-1:0]  car_mode;
    logic [ffec_pkg::FLOOR_W-1:0] car_floor;
    logic [ffec_pkg::FLOOR_W-1:0] call_at;
    logic [ffec_pkg::FLOOR_W-1:0] dest_at;
    logic                         trip_upward;
    logic [ffec_pkg::DUTY_W-1:0]  duty_now;
    logic [ffec_pkg::FLOOR_W-1:0] shown_at;
    logic [ffec_pkg::DUTY_W-1:0]  up_duty_cfg;
    logic [ffec_pkg::DUTY_W-1:0]  down_duty_cfg;

    ffec_pkg::t_out_item status_due_q[$];
    t_script_row         script_q[$];
    bit                  row_typed;
    ffec_pkg::t_out_item row_status;
    int                  err_cnt;
    int                  phase_no;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // Mode machine of the car for one poll tick
    task automatic advance_car(input ffec_pkg::t_in_item tk, output ffec_pkg::t_out_item st);
        logic [ffec_pkg::MOTOR_W-1:0] motor;
        logic [ffec_pkg::FLOOR_W-1:0] cf;
        logic                         cu;
        logic                         take;
        motor = ffec_pkg::MOT_STOP;
        take  = 1'b1;
        cf    = ffec_pkg::FLOOR_NONE;
        cu    = 1'b0;
        // Limit switch fixes the floor
        if (tk.limit_hit) begin
            car_floor = {1'b0, tk.limit_index} + ffec_pkg::FLOOR_1;
            shown_at  = car_floor;
        end
        // Cab button always rewrites the destination; it starts a trip only in wait
        if (tk.cab_hit) begin
            dest_at = {1'b0, tk.cab_index} + ffec_pkg::FLOOR_1;
            if (car_mode == ffec_pkg::MODE_WAIT && dest_at != car_floor) begin
                if (trip_upward && dest_at > car_floor)
                    car_mode = ffec_pkg::MODE_UPR;
                else if (!trip_upward && dest_at < car_floor)
                    car_mode = ffec_pkg::MODE_DNR;
            end
        end
        // Hall call, taken only in idle
        if (tk.hall_hit && car_mode == ffec_pkg::MODE_IDLE) begin
            case (tk.hall_code)
                ffec_pkg::HALL_F1_UP: begin
                    cf = ffec_pkg::FLOOR_1;
                    cu = 1'b1;
                end
                ffec_pkg::HALL_F2_DOWN: cf = ffec_pkg::FLOOR_2;
                ffec_pkg::HALL_F2_UP: begin
                    cf = ffec_pkg::FLOOR_2;
                    cu = 1'b1;
                end
                ffec_pkg::HALL_F3_DOWN: cf = ffec_pkg::FLOOR_3;
                ffec_pkg::HALL_F3_UP: begin
                    cf = ffec_pkg::FLOOR_3;
                    cu = 1'b1;
                end
                ffec_pkg::HALL_F4_DOWN: cf = ffec_pkg::FLOOR_4;
                default: take = 1'b0;
            endcase
            if (take) begin
                call_at     = cf;
                trip_upward = cu;
                if (car_floor == cf) begin
                    car_mode = ffec_pkg::MODE_WAIT;
                end else if (cf == ffec_pkg::FLOOR_1 || car_floor > cf) begin
                    duty_now = down_duty_cfg;
                    car_mode = ffec_pkg::MODE_DNC;
                end else begin
                    duty_now = up_duty_cfg;
                    car_mode = ffec_pkg::MODE_UPC;
                end
            end
        end
        // Drive or stop
        case (car_mode)
            ffec_pkg::MODE_INIT: begin
                if (car_floor == ffec_pkg::FLOOR_1) begin
                    car_mode = ffec_pkg::MODE_IDLE;
                end else begin
                    duty_now = down_duty_cfg;
                    motor    = ffec_pkg::MOT_DOWN;
                end
            end
            ffec_pkg::MODE_UPC: begin
                if (call_at == car_floor) begin
                    car_mode = ffec_pkg::MODE_WAIT;
                end else begin
                    duty_now = up_duty_cfg;
                    motor    = ffec_pkg::MOT_UP;
                end
            end
            ffec_pkg::MODE_DNC: begin
                if (call_at == car_floor) begin
                    car_mode = ffec_pkg::MODE_WAIT;
                end else begin
                    duty_now = down_duty_cfg;
                    motor    = ffec_pkg::MOT_DOWN;
                end
            end
            ffec_pkg::MODE_UPR: begin
                if (dest_at == car_floor) begin
                    car_mode = ffec_pkg::MODE_IDLE;
                end else begin
                    duty_now = up_duty_cfg;
                    motor    = ffec_pkg::MOT_UP;
                end
            end
            ffec_pkg::MODE_DNR: begin
                if (dest_at == car_floor) begin
                    car_mode = ffec_pkg::MODE_IDLE;
                end else begin
                    duty_now = down_duty_cfg;
                    motor    = ffec_pkg::MOT_DOWN;
                end
            end
            default: ;
        endcase
        st.motor_cmd     = motor;
        st.duty          = duty_now;
        st.display_floor = shown_at;
        st.mode          = car_mode;
    endtask

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic ffec_pkg::t_in_item mk_tick(
        input logic lh, input logic [ffec_pkg::INDEX_W-1:0] li,
        input logic ch, input logic [ffec_pkg::INDEX_W-1:0] ci,
        input logic hh, input logic [ffec_pkg::HALL_W-1:0] hc);
        ffec_pkg::t_in_item tk;
        tk.limit_hit   = lh;
        tk.limit_index = li;
        tk.cab_hit     = ch;
        tk.cab_index   = ci;
        tk.hall_hit    = hh;
        tk.hall_code   = hc;
        return tk;
    endfunction

    // Plausible next tick from where the car is now; some noise mixed in
    function automatic ffec_pkg::t_in_item next_tick();
        ffec_pkg::t_in_item tk;
        int                 f;
        int unsigned        rnd;
        tk = '0;
        if ($urandom_range(0, 99) < 12) begin
            rnd = $urandom();
            tk  = rnd[$bits(ffec_pkg::t_in_item)-1:0];
            return tk;
        end
        if (car_mode != ffec_pkg::MODE_IDLE && car_mode != ffec_pkg::MODE_WAIT &&
            $urandom_range(0, 99) < 35) begin
            if (car_floor == ffec_pkg::FLOOR_NONE)
                f = $urandom_range(1, 4);
            else if (car_mode == ffec_pkg::MODE_UPC || car_mode == ffec_pkg::MODE_UPR)
                f = (car_floor >= ffec_pkg::FLOOR_4) ? 4 : car_floor + 1;
            else
                f = (car_floor <= ffec_pkg::FLOOR_1) ? 1 : car_floor - 1;
            tk.limit_hit   = 1'b1;
            tk.limit_index = ffec_pkg::INDEX_W'(f - 1);
        end
        if (car_mode == ffec_pkg::MODE_IDLE && $urandom_range(0, 99) < 50) begin
            tk.hall_hit  = 1'b1;
            tk.hall_code = ($urandom_range(0, 9) == 0) ?
                           ffec_pkg::HALL_W'($urandom_range(0, 7)) :
                           ffec_pkg::HALL_W'($urandom_range(2, 7));
        end
        if (car_mode == ffec_pkg::MODE_WAIT && $urandom_range(0, 99) < 50) begin
            tk.cab_hit   = 1'b1;
            tk.cab_index = ffec_pkg::INDEX_W'($urandom_range(0, 3));
        end
        // Stray presses in any mode
        if ($urandom_range(0, 9) == 0) begin
            tk.cab_hit   = 1'b1;
            tk.cab_index = ffec_pkg::INDEX_W'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 9) == 0) begin
            tk.hall_hit  = 1'b1;
            tk.hall_code = ffec_pkg::HALL_W'($urandom_range(0, 7));
        end
        return tk;
    endfunction

    // Offer one tick and hold it until the transfer; valid stays high on return
    task automatic send_tick(input ffec_pkg::t_in_item tk, input bit typed,
                             input ffec_pkg::t_out_item st);
        row_typed  = typed;
        row_status = st;
        i_in       = tk;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int n);
        i_in_valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Wait until every expected status has come back
    task automatic drain();
        i_in_valid = 1'b0;
        while (status_due_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_duty(input logic [ffec_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [ffec_pkg::DUTY_W-1:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_wr_en = 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Track writes and transfers, predict and compare
    always @(posedge i_clk) begin : track
        ffec_pkg::t_out_item pred;
        ffec_pkg::t_out_item want;
        if (!i_rst_n) begin
            car_mode      = ffec_pkg::MODE_INIT;
            car_floor     = ffec_pkg::FLOOR_NONE;
            call_at       = ffec_pkg::FLOOR_NONE;
            dest_at       = ffec_pkg::FLOOR_NONE;
            trip_upward   = 1'b0;
            duty_now      = ffec_pkg::DUTY_RST;
            shown_at      = ffec_pkg::FLOOR_NONE;
            up_duty_cfg   = ffec_pkg::UP_DUTY_RST;
            down_duty_cfg = ffec_pkg::DOWN_DUTY_RST;
            status_due_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ffec_pkg::CFG_UP_DUTY:   up_duty_cfg   = i_cfg_data;
                    ffec_pkg::CFG_DOWN_DUTY: down_duty_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                advance_car(i_in, pred);
                status_due_q.push_back(row_typed ? row_status : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (status_due_q.size() == 0) begin
                    report_mismatch($sformatf("status with none expected: %h", o_out));
                end else begin
                    want = status_due_q.pop_front();
                    if (o_out.motor_cmd !== want.motor_cmd)
                        report_mismatch($sformatf("motor_cmd got %0d want %0d",
                                                  o_out.motor_cmd, want.motor_cmd));
                    if (o_out.duty !== want.duty)
                        report_mismatch($sformatf("duty got %0d want %0d",
                                                  o_out.duty, want.duty));
                    if (o_out.display_floor !== want.display_floor)
                        report_mismatch($sformatf("display_floor got %0d want %0d",
                                                  o_out.display_floor, want.display_floor));
                    if (o_out.mode !== want.mode)
                        report_mismatch($sformatf("mode got %0d want %0d",
                                                  o_out.mode, want.mode));
                end
            end
        end
    end

    // Downstream stall: random bursts by segment, one long hold-off in the second phase
    initial begin : out_stall_gen
        int  seg;
        int  lvl;
        int  burst;
        bit  held;
        held        = 1'b0;
        burst       = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            lvl = $urandom_range(0, 2);
            for (seg = 0; seg < 40; seg++) begin
                @(negedge i_clk);
                if (!held && phase_no == 2) begin
                    held        = 1'b1;
                    i_out_stall = 1'b1;
                    repeat (60) @(negedge i_clk);
                end
                if (burst > 0) begin
                    i_out_stall = 1'b1;
                    burst--;
                end else if (lvl > 0 && $urandom_range(0, 9) < lvl * 2) begin
                    i_out_stall = 1'b1;
                    burst       = gap_len() - 1;
                end else begin
                    i_out_stall = 1'b0;
                end
            end
        end
    end

    // Stimulus
    initial begin : stim
        int ph;
        int n;
        int send_lvl;
        err_cnt     = 0;
        phase_no    = 0;
        row_typed   = 1'b0;
        row_status  = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = ffec_pkg::CFG_UP_DUTY;
        i_cfg_data  = '0;

        // Directed walk: known status at first, then the predictor takes over
        script_q = '{
            '{mk_tick(0, 0, 0, 0, 0, HALL_IGNORED_0), 1'b1,
              '{ffec_pkg::MOT_DOWN, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_NONE,
                ffec_pkg::MODE_INIT}},
            '{mk_tick(1, 2, 1, 3, 1, ffec_pkg::HALL_F4_DOWN), 1'b1,
              '{ffec_pkg::MOT_DOWN, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_3,
                ffec_pkg::MODE_INIT}},
            '{mk_tick(1, 0, 0, 0, 0, HALL_IGNORED_0), 1'b1,
              '{ffec_pkg::MOT_STOP, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_IDLE}},
            '{mk_tick(0, 0, 0, 0, 1, HALL_IGNORED_0), 1'b1,
              '{ffec_pkg::MOT_STOP, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_IDLE}},
            '{mk_tick(0, 0, 0, 0, 1, HALL_IGNORED_1), 1'b1,
              '{ffec_pkg::MOT_STOP, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_IDLE}},
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F1_UP), 1'b1,
              '{ffec_pkg::MOT_STOP, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_WAIT}},
            '{mk_tick(0, 0, 1, 0, 0, HALL_IGNORED_0), 1'b1,
              '{ffec_pkg::MOT_STOP, ffec_pkg::DOWN_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_WAIT}},
            '{mk_tick(0, 0, 1, 3, 0, HALL_IGNORED_0), 1'b1,
              '{ffec_pkg::MOT_UP, ffec_pkg::UP_DUTY_RST, ffec_pkg::FLOOR_1,
                ffec_pkg::MODE_UPR}},
            // hall call while riding is dropped
            '{mk_tick(1, 1, 0, 0, 1, ffec_pkg::HALL_F2_DOWN), 1'b0, '0},
            '{mk_tick(1, 3, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F4_DOWN), 1'b0, '0},
            '{mk_tick(0, 0, 1, 1, 0, HALL_IGNORED_0), 1'b0, '0},
            // destination rewritten while riding down
            '{mk_tick(1, 2, 1, 2, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F2_DOWN), 1'b0, '0},
            '{mk_tick(1, 1, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            // cab button against the call direction keeps the car waiting
            '{mk_tick(0, 0, 1, 3, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 1, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(1, 0, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F3_UP), 1'b0, '0},
            '{mk_tick(1, 2, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 1, 3, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(1, 3, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            // first floor called from above drives down
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F1_UP), 1'b0, '0},
            '{mk_tick(1, 0, 1, 2, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 1, 1, 1, ffec_pkg::HALL_F2_UP), 1'b0, '0},
            '{mk_tick(1, 1, 0, 0, 0, HALL_IGNORED_0), 1'b0, '0},
            '{mk_tick(0, 0, 0, 0, 1, ffec_pkg::HALL_F3_DOWN), 1'b0, '0},
            '{mk_tick(1, 2, 1, 1, 1, ffec_pkg::HALL_F2_UP), 1'b0, '0}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (script_q[k]) begin
            if ($urandom_range(0, 3) == 0)
                idle_for(gap_len());
            send_tick(script_q[k].tick, script_q[k].typed, script_q[k].status);
        end

        // Random trips, one duty setting per phase
        for (ph = 1; ph <= 4; ph++) begin
            drain();
            case (ph)
                1: begin
                    write_duty(ffec_pkg::CFG_UP_DUTY, 10'd999);
                    write_duty(ffec_pkg::CFG_DOWN_DUTY, 10'd0);
                end
                2: begin
                    write_duty(ffec_pkg::CFG_UP_DUTY, 10'd0);
                    write_duty(ffec_pkg::CFG_DOWN_DUTY, 10'd999);
                end
                default: begin
                    write_duty(ffec_pkg::CFG_UP_DUTY,
                               ffec_pkg::DUTY_W'($urandom_range(0, 999)));
                    write_duty(ffec_pkg::CFG_DOWN_DUTY,
                               ffec_pkg::DUTY_W'($urandom_range(0, 999)));
                end
            endcase
            phase_no = ph;
            send_lvl = 0;
            for (n = 0; n < 460; n++) begin
                if (n % 50 == 0)
                    send_lvl = $urandom_range(0, 2);
                if (send_lvl > 0 && $urandom_range(0, 9) < send_lvl * 2)
                    idle_for(gap_len());
                send_tick(next_tick(), 1'b0, '0);
            end
        end

        drain();
        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
